// ----- rtl/core/heater_standby_valve_control_assert.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef HEATER_STANDBY_VALVE_CONTROL_ASSERT_SVH
`define HEATER_STANDBY_VALVE_CONTROL_ASSERT_SVH
`ifndef SYNTHESIS
`define HSVC_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("hsvc assertion failed");
`define HSVC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("hsvc assertion failed");
`else
`define HSVC_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define HSVC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif
`endif

// ----- rtl/core/hsvc_pkg.sv -----
package hsvc_pkg;

  // valve PWM ceiling, legal 100..255
  localparam logic [7:0] PWM_TOP = 8'd255;

  localparam logic [7:0] FLOOR_MIN = 8'd100;
  localparam logic [7:0] FLOOR_MAX = 8'd255;

  // config register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINTER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN_TARGET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALVE_BASE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTDOOR_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_RELOAD = 3'd5;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] LAMP_NONE   = 2'd0;
  localparam logic [1:0] LAMP_STEADY = 2'd1;
  localparam logic [1:0] LAMP_BLINK  = 2'd2;

  // error bands on target - return
  localparam logic signed [16:0] HEAT_BAND      = 17'sd200;
  localparam logic signed [16:0] BLINK_BAND     = 17'sd500;
  localparam logic signed [16:0] COOL_BAND      = 17'sd250;
  localparam logic signed [16:0] COOL_STEP_BAND = 17'sd500;

  // x/1000 as (x*M)>>28, exact for x < 2^18
  localparam logic [18:0] DIV1000_MUL   = 19'd268436;
  localparam int unsigned DIV1000_SHIFT = 28;
  // product at or above this gives a floor of 255 regardless of base
  localparam logic [31:0] FLOOR_SAT_PRODUCT = 32'd255000;

  // x/100 as (x*M)>>24, exact for x <= 2^16
  localparam logic [17:0] DIV100_MUL   = 18'd167773;
  localparam int unsigned DIV100_SHIFT = 24;

  typedef struct packed {
    logic              winter_mode;
    logic signed [15:0] return_target;
    logic [7:0]        valve_base;
    logic [15:0]       angle_gain;
    logic signed [15:0] outdoor_limit;
    logic [15:0]       holdoff_reload;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic signed [15:0] outdoor_temp;
    logic signed [15:0] return_temp;
    logic signed [15:0] supply_temp;
  } in_item_t;

  typedef struct packed {
    logic        heat_req;
    logic        heat_big;
    logic        cool_req;
    logic        cool_big;
    logic        supply_ok;
  } band_t;

  typedef struct packed {
    logic              func;
    logic              below_limit;
    logic [31:0]       product;
    logic signed [16:0] diff;
    band_t             band;
  } prep_t;

  typedef struct packed {
    logic              func;
    logic              below_limit;
    logic              floor_sat;
    logic [7:0]        quot;
    logic signed [10:0] err;
    band_t             band;
  } scale_t;

  typedef struct packed {
    logic [7:0] valve_opening;
    logic [7:0] valve_floor;
    logic       pump_on;
    logic [1:0] lamp_mode;
  } result_t;

endpackage

// ----- rtl/core/hsvc_in_if.sv -----
interface hsvc_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic signed [15:0] outdoor_temp;
  logic signed [15:0] return_temp;
  logic signed [15:0] supply_temp;

  modport source (output valid, func, outdoor_temp, return_temp, supply_temp, input ready);
  modport sink (input valid, func, outdoor_temp, return_temp, supply_temp, output ready);
endinterface

// ----- rtl/core/hsvc_out_if.sv -----
interface hsvc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] valve_opening;
  logic [7:0] valve_floor;
  logic       pump_on;
  logic [1:0] lamp_mode;

  modport source (output valid, valve_opening, valve_floor, pump_on, lamp_mode, input ready);
  modport sink (input valid, valve_opening, valve_floor, pump_on, lamp_mode, output ready);
endinterface

// ----- rtl/core/heater_standby_valve_control.sv -----
// Pipeline: input register, product, constant divides, state update + result
//   register. Throughput: one item per cycle while the output is not stalled;
//   the valve/floor/pump/hold-off loop closes in the single state-update stage,
//   so back-to-back items never wait on each other.
// Reset (rst, synchronous): valve, floor, pump, hold-off timer and all config
//   registers go to zero; the pipeline empties.
`include "heater_standby_valve_control_assert.svh"

module heater_standby_valve_control (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hsvc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsvc_pkg::CFG_DATA_W-1:0]    cfg_data,
  hsvc_in_if.sink                            in_ch,
  hsvc_out_if.source                         out_ch
);

  // Config registers. The user must write them only while the block is idle (not
  // enforced by the block); pipeline stages read them live without a shadow copy.
  hsvc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsvc_pkg::CFG_WINTER_MODE:    cfg.winter_mode    <= cfg_data[0];
        hsvc_pkg::CFG_RETURN_TARGET:  cfg.return_target  <= $signed(cfg_data);
        hsvc_pkg::CFG_VALVE_BASE:     cfg.valve_base     <= cfg_data[7:0];
        hsvc_pkg::CFG_ANGLE_GAIN:     cfg.angle_gain     <= cfg_data;
        hsvc_pkg::CFG_OUTDOOR_LIMIT:  cfg.outdoor_limit  <= $signed(cfg_data);
        hsvc_pkg::CFG_HOLDOFF_RELOAD: cfg.holdoff_reload <= cfg_data;
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // Input item from the channel.
  hsvc_pkg::in_item_t in_item;

  assign in_item.func         = in_ch.func;
  assign in_item.outdoor_temp = in_ch.outdoor_temp;
  assign in_item.return_temp  = in_ch.return_temp;
  assign in_item.supply_temp  = in_ch.supply_temp;

  // Stage 1-2: input register, then deficit*gain and the error band flags.
  logic            prep_valid;
  logic            prep_ready;
  hsvc_pkg::prep_t prep_data;

  hsvc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_item),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  // Stage 3: reciprocal multiplies for /1000 (floor) and /100 (error).
  logic             scale_valid;
  logic             scale_ready;
  hsvc_pkg::scale_t scale_data;

  hsvc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (scale_valid),
    .out_ready (scale_ready),
    .out_data  (scale_data)
  );

  // Stage 4: heat / cool / hold decisions against the live state, result
  // register. The result register also acts as the output buffer: a new item
  // is taken in the same cycle the waiting one leaves.
  hsvc_pkg::result_t result;

  hsvc_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (scale_valid),
    .in_ready  (scale_ready),
    .in_data   (scale_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (result)
  );

  assign out_ch.valve_opening = result.valve_opening;
  assign out_ch.valve_floor   = result.valve_floor;
  assign out_ch.pump_on       = result.pump_on;
  assign out_ch.lamp_mode     = result.lamp_mode;

  // Floor is either its reset value or saturated into 100..255.
  `HSVC_ASSERT_IMP(a_floor_range, clk, rst, out_ch.valid,
    (out_ch.valve_floor == 8'd0 || out_ch.valve_floor >= hsvc_pkg::FLOOR_MIN))
  // Any lamp command comes only from a winter-mode sample.
  `HSVC_ASSERT_IMP(a_lamp_winter, clk, rst,
    out_ch.valid && out_ch.lamp_mode != hsvc_pkg::LAMP_NONE, cfg.winter_mode)
  // Taken result with nothing behind it leaves the output empty.
  `HSVC_ASSERT_NEXT(a_out_drain, clk, rst,
    out_ch.valid && out_ch.ready && !scale_valid, !out_ch.valid)

endmodule

// ----- rtl/core/hsvc_prep.sv -----
// Input register, then deficit product, error and band flags.
module hsvc_prep (
  input  logic              clk,
  input  logic              rst,
  input  hsvc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvc_pkg::prep_t   out_data
);

  logic              v1;
  hsvc_pkg::in_item_t r1;
  logic              take1;
  logic              ready2;
  logic              take2;
  logic signed [16:0] deficit;
  logic signed [16:0] diff;
  hsvc_pkg::prep_t   prep_next;

  assign ready2   = !out_valid || out_ready;
  assign take2    = v1 && ready2;
  assign in_ready = !v1 || take2;
  assign take1    = in_valid && in_ready;

  always_comb begin
    deficit = $signed({cfg.outdoor_limit[15], cfg.outdoor_limit})
            - $signed({r1.outdoor_temp[15], r1.outdoor_temp});
    diff    = $signed({cfg.return_target[15], cfg.return_target})
            - $signed({r1.return_temp[15], r1.return_temp});
    prep_next.func            = r1.func;
    prep_next.below_limit     = deficit > 17'sd0;
    prep_next.product         = 32'(deficit[15:0]) * 32'(cfg.angle_gain);
    prep_next.diff            = diff;
    prep_next.band.heat_req   = diff >= hsvc_pkg::HEAT_BAND;
    prep_next.band.heat_big   = diff > hsvc_pkg::BLINK_BAND;
    prep_next.band.cool_req   = diff < -hsvc_pkg::COOL_BAND;
    prep_next.band.cool_big   = diff <= -hsvc_pkg::COOL_STEP_BAND;
    prep_next.band.supply_ok  = r1.supply_temp >= cfg.return_target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take1) begin
        v1 <= 1'b1;
      end else if (take2) begin
        v1 <= 1'b0;
      end
      if (take2) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      r1 <= in_data;
    end
    if (take2) begin
      out_data <= prep_next;
    end
  end

endmodule

// ----- rtl/core/hsvc_scale.sv -----
// Constant divides: product/1000 for the floor, diff/100 for the error.
module hsvc_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsvc_pkg::prep_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsvc_pkg::scale_t out_data
);

  logic             take;
  logic [36:0]      quot_prod;
  logic [16:0]      mag;
  logic [34:0]      err_prod;
  logic [9:0]       err_mag;
  hsvc_pkg::scale_t scale_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    quot_prod = 37'(in_data.product[17:0]) * 37'(hsvc_pkg::DIV1000_MUL);
    mag       = in_data.diff[16] ? $unsigned(-in_data.diff) : $unsigned(in_data.diff);
    err_prod  = 35'(mag) * 35'(hsvc_pkg::DIV100_MUL);
    err_mag   = err_prod[hsvc_pkg::DIV100_SHIFT+9:hsvc_pkg::DIV100_SHIFT];
    scale_next.func        = in_data.func;
    scale_next.below_limit = in_data.below_limit;
    scale_next.floor_sat   = in_data.product >= hsvc_pkg::FLOOR_SAT_PRODUCT;
    scale_next.quot        = quot_prod[hsvc_pkg::DIV1000_SHIFT+7:hsvc_pkg::DIV1000_SHIFT];
    // truncate toward zero: divide the magnitude, then restore the sign
    scale_next.err         = in_data.diff[16] ? -$signed({1'b0, err_mag})
                                              : $signed({1'b0, err_mag});
    scale_next.band        = in_data.band;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= scale_next;
    end
  end

endmodule

// ----- rtl/core/hsvc_state.sv -----
// Regulator state update and result register.
module hsvc_state (
  input  logic              clk,
  input  logic              rst,
  input  hsvc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvc_pkg::scale_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvc_pkg::result_t out_data
);

  logic        take;
  logic [7:0]  valve;
  logic [7:0]  valve_next;
  logic [7:0]  floor_q;
  logic [7:0]  floor_next;
  logic        pump;
  logic        pump_next;
  logic [15:0] holdoff;
  logic [15:0] holdoff_next;
  logic [1:0]  lamp;
  logic [8:0]  floor_sum;
  logic [7:0]  floor_cand;
  logic signed [11:0] vsum;

  function automatic logic [7:0] clamp_valve(input logic signed [11:0] x,
                                             input logic [7:0] fl);
    logic signed [11:0] y;
    y = x;
    if (y < $signed({4'b0000, fl})) y = $signed({4'b0000, fl});
    if (y > $signed({4'b0000, hsvc_pkg::PWM_TOP})) y = $signed({4'b0000, hsvc_pkg::PWM_TOP});
    if (y < 12'sd0) y = 12'sd0;
    if (y > 12'sd255) y = 12'sd255;
    return y[7:0];
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    floor_sum  = {1'b0, cfg.valve_base} + {1'b0, in_data.quot};
    if (in_data.floor_sat || floor_sum[8]) begin
      floor_cand = hsvc_pkg::FLOOR_MAX;
    end else if (floor_sum[7:0] < hsvc_pkg::FLOOR_MIN) begin
      floor_cand = hsvc_pkg::FLOOR_MIN;
    end else begin
      floor_cand = floor_sum[7:0];
    end

    valve_next   = valve;
    floor_next   = floor_q;
    pump_next    = pump;
    holdoff_next = holdoff;
    lamp         = hsvc_pkg::LAMP_NONE;
    vsum         = 12'sd0;

    if (in_data.func == hsvc_pkg::FUNC_TICK) begin
      if (holdoff != 16'd0) begin
        holdoff_next = holdoff - 16'd1;
      end
    end else if (cfg.winter_mode) begin
      if (in_data.below_limit) begin
        floor_next = floor_cand;
      end
      // heating
      if (in_data.band.heat_req && holdoff_next == 16'd0) begin
        holdoff_next = cfg.holdoff_reload;
        vsum = $signed({4'b0000, valve_next}) + $signed({in_data.err[10], in_data.err});
        if (vsum < 12'sd0) vsum = 12'sd0;
        valve_next = clamp_valve(vsum, floor_next);
        if (in_data.band.heat_big) begin
          pump_next = 1'b1;
          lamp      = hsvc_pkg::LAMP_BLINK;
        end else begin
          pump_next = 1'b0;
          lamp      = hsvc_pkg::LAMP_STEADY;
        end
      end
      // cooling
      if (in_data.band.cool_req && holdoff_next == 16'd0) begin
        holdoff_next = cfg.holdoff_reload;
        valve_next   = clamp_valve($signed({4'b0000, valve_next}), floor_next);
        if (pump_next) begin
          pump_next = 1'b0;
          lamp      = hsvc_pkg::LAMP_STEADY;
        end
        if (in_data.band.cool_big) begin
          vsum = $signed({4'b0000, valve_next}) + $signed({in_data.err[10], in_data.err});
          if (vsum < 12'sd0) vsum = 12'sd0;
          if (vsum > 12'sd255) vsum = 12'sd255;
          valve_next = vsum[7:0];
        end
      end
      // hold
      if (holdoff_next == 16'd0) begin
        holdoff_next = cfg.holdoff_reload;
        if (in_data.band.supply_ok) begin
          pump_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valve     <= 8'd0;
      floor_q   <= 8'd0;
      pump      <= 1'b0;
      holdoff   <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        valve     <= valve_next;
        floor_q   <= floor_next;
        pump      <= pump_next;
        holdoff   <= holdoff_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.valve_opening <= valve_next;
      out_data.valve_floor   <= floor_next;
      out_data.pump_on       <= pump_next;
      out_data.lamp_mode     <= lamp;
    end
  end

endmodule

// ----- test/hsvc_regulation_checker.sv -----
module hsvc_regulation_checker
  import hsvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hsvc_in_if                    in_mon,
  hsvc_out_if                   out_mon,
  output int                    mismatches,
  output int                    pending,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic               winter_q;
  logic signed [15:0] target_q;
  logic [7:0]         base_q;
  logic [15:0]        gain_q;
  logic signed [15:0] limit_q;
  logic [15:0]        reload_q;

  // regulator state
  logic [7:0]  valve_q;
  logic [7:0]  floor_q;
  logic        pump_q;
  logic [15:0] hold_q;

  result_t valve_results_due[$];

  // floor first, then the PWM ceiling, then the 8-bit range
  function automatic logic [7:0] clamp_to_window(input longint v);
    if (v < longint'(floor_q)) v = longint'(floor_q);
    if (v > longint'(PWM_TOP)) v = longint'(PWM_TOP);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic result_t regulate(input logic func,
                                       input logic signed [15:0] od,
                                       input logic signed [15:0] rt,
                                       input logic signed [15:0] sp);
    longint outdoor, ret, sup, tgt, diff, err, fl, v;
    logic [1:0] lamp;
    result_t res;
    lamp = LAMP_NONE;
    if (func == FUNC_TICK) begin
      if (hold_q != 0) hold_q = hold_q - 16'd1;
    end else if (winter_q) begin
      outdoor = od;
      ret     = rt;
      sup     = sp;
      tgt     = target_q;
      if (outdoor < longint'(limit_q)) begin
        fl = longint'(base_q) + ((longint'(limit_q) - outdoor) * longint'(gain_q)) / 1000;
        if (fl > 255) fl = 255;
        if (fl < 100) fl = 100;
        floor_q = fl[7:0];
      end
      diff = tgt - ret;
      err  = diff / 100;  // truncates toward zero
      if (ret <= tgt - 200 && hold_q == 0) begin
        hold_q = reload_q;
        v = longint'(valve_q) + err;
        if (v < 0) v = 0;
        valve_q = clamp_to_window(v);
        if (ret < tgt - 500) begin
          pump_q = 1'b1;
          lamp   = LAMP_BLINK;
        end else begin
          pump_q = 1'b0;
          lamp   = LAMP_STEADY;
        end
      end
      if (ret > tgt + 250 && hold_q == 0) begin
        hold_q  = reload_q;
        valve_q = clamp_to_window(longint'(valve_q));
        if (pump_q) begin
          pump_q = 1'b0;
          lamp   = LAMP_STEADY;
        end
        if (ret >= tgt + 500) begin
          // big cooling step ignores the floor
          v = longint'(valve_q) + err;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          valve_q = v[7:0];
        end
      end
      if (hold_q == 0) begin
        hold_q = reload_q;
        if (sup >= tgt) pump_q = 1'b0;
      end
    end
    res.valve_opening = valve_q;
    res.valve_floor   = floor_q;
    res.pump_on       = pump_q;
    res.lamp_mode     = lamp;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      winter_q = 1'b0;
      target_q = '0;
      base_q   = '0;
      gain_q   = '0;
      limit_q  = '0;
      reload_q = '0;
      valve_q  = '0;
      floor_q  = '0;
      pump_q   = 1'b0;
      hold_q   = '0;
      valve_results_due.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINTER_MODE:    winter_q = cfg_data[0];
          CFG_RETURN_TARGET:  target_q = cfg_data;
          CFG_VALVE_BASE:     base_q   = cfg_data[7:0];
          CFG_ANGLE_GAIN:     gain_q   = cfg_data;
          CFG_OUTDOOR_LIMIT:  limit_q  = cfg_data;
          CFG_HOLDOFF_RELOAD: reload_q = cfg_data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.valve_opening = out_mon.valve_opening;
        got.valve_floor   = out_mon.valve_floor;
        got.pump_on       = out_mon.pump_on;
        got.lamp_mode     = out_mon.lamp_mode;
        if (valve_results_due.size() == 0) begin
          $error("unexpected result: valve %0d floor %0d pump %0d lamp %0d",
                 got.valve_opening, got.valve_floor, got.pump_on, got.lamp_mode);
          mismatches++;
        end else begin
          want = valve_results_due.pop_front();
          checked++;
          if (got.valve_opening !== want.valve_opening) begin
            $error("valve_opening: expected %0d, got %0d",
                   want.valve_opening, got.valve_opening);
            mismatches++;
          end
          if (got.valve_floor !== want.valve_floor) begin
            $error("valve_floor: expected %0d, got %0d", want.valve_floor, got.valve_floor);
            mismatches++;
          end
          if (got.pump_on !== want.pump_on) begin
            $error("pump_on: expected %0d, got %0d", want.pump_on, got.pump_on);
            mismatches++;
          end
          if (got.lamp_mode !== want.lamp_mode) begin
            $error("lamp_mode: expected %0d, got %0d", want.lamp_mode, got.lamp_mode);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        valve_results_due.push_back(regulate(in_mon.func, in_mon.outdoor_temp,
                                             in_mon.return_temp, in_mon.supply_temp));
    end
    pending = valve_results_due.size();
  end

endmodule

// ----- test/heater_standby_valve_control_tb.sv -----
module heater_standby_valve_control_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsvc_pkg::*;

  // Idle time after the last expected result, to let the pipeline drain before
  // touching registers or ending the run.
  localparam int DRAIN_CYCLES = 8;
  // Longest legal quiet stretch is the RESULT_HOLD output hold-off plus a gap.
  localparam int STALL_LIMIT  = 2000;
  localparam int RESULT_HOLD  = 300;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_ITEMS  = 56;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int checked;
  int items_sent;
  int settings_used;
  int cur_target;
  int cur_limit;
  bit calm;  // set for phases with no idling on either side

  hsvc_in_if  in_ch();
  hsvc_out_if out_ch();

  heater_standby_valve_control i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  hsvc_regulation_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps, an occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid is only lowered when a gap follows, so a back-to-back item never
  // sees valid dropped and raised in the same step.
  task automatic send_item(input logic f, input int od, input int rt, input int sp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.outdoor_temp <= od[15:0];
    in_ch.return_temp  <= rt[15:0];
    in_ch.supply_temp  <= sp[15:0];
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Wait for every expected result, then let the pipeline drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all six registers back to back; only legal when idle.
  task automatic load_config(input int winter, input int target, input int base,
                             input int gain, input int limit, input int reload);
    logic [CFG_IDX_W-1:0] idx[6];
    int                   vals[6];
    idx  = '{CFG_WINTER_MODE, CFG_RETURN_TARGET, CFG_VALVE_BASE,
             CFG_ANGLE_GAIN, CFG_OUTDOOR_LIMIT, CFG_HOLDOFF_RELOAD};
    vals = '{winter, target, base, gain, limit, reload};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i][15:0];
      @(negedge clk);
    end
    cfg_we     <= 1'b0;
    cur_target = target;
    cur_limit  = limit;
    settings_used++;
  endtask

  // Most samples sit around the target and the outdoor limit so that all
  // three bands and the floor update get hit; the rest is full-range noise.
  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)
      send_item(FUNC_TICK, $urandom, $urandom, $urandom);
    else if (sel < 85)
      send_item(FUNC_SAMPLE,
                clip16(cur_limit + int'($urandom_range(0, 400)) - 300),
                clip16(cur_target + int'($urandom_range(0, 1800)) - 900),
                clip16(cur_target + int'($urandom_range(0, 600)) - 300));
    else
      send_item(FUNC_SAMPLE, $urandom, $urandom, $urandom);
  endtask

  // Stimulus and verdict
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_TICK;
    in_ch.outdoor_temp = '0;
    in_ch.return_temp  = '0;
    in_ch.supply_temp  = '0;
    items_sent         = 0;
    settings_used      = 0;
    cur_target         = 0;
    cur_limit          = 0;
    calm               = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of winter: a sample must leave everything at reset values, a tick
    // runs anyway.
    send_item(FUNC_SAMPLE, -1000, -1000, 0);
    send_item(FUNC_TICK, 0, 0, 0);
    settle();

    // target 1000, floor from outdoor below 100, no hold-off
    load_config(1, 1000, 50, 2000, 100, 0);
    send_item(FUNC_SAMPLE, 50, 400, 0);       // cold: new floor, heat far below, blink
    send_item(FUNC_SAMPLE, 200, 700, 0);      // heat near band: steady, pump off
    send_item(FUNC_SAMPLE, 200, 400, 2000);   // heat, then hold drops pump on warm supply
    send_item(FUNC_SAMPLE, 200, 400, 0);      // heat far below again: pump back on
    send_item(FUNC_SAMPLE, 200, 1300, 0);     // small cool with pump on: steady lamp
    send_item(FUNC_SAMPLE, 200, 2500, 0);     // big cool step down to the floor
    send_item(FUNC_SAMPLE, 200, 32767, 0);    // cool step saturates at zero
    send_item(FUNC_SAMPLE, 200, 1100, 1000);  // dead band, hold only
    send_item(FUNC_SAMPLE, -32768, -32768, -32768);  // floor and valve hit 255
    send_item(FUNC_SAMPLE, 32767, 32767, 32767);
    send_item(FUNC_TICK, 32767, -32768, 32767);
    settle();

    // zero base and gain: floor saturates up to its minimum; hold-off of 3
    load_config(1, 0, 0, 0, 0, 3);
    send_item(FUNC_SAMPLE, -5, -600, 0);      // acts, loads the timer
    send_item(FUNC_SAMPLE, -5, -600, 0);      // timer running, nothing happens
    repeat (4) send_item(FUNC_TICK, 0, 0, 0); // last tick at zero stays at zero
    send_item(FUNC_SAMPLE, -5, -600, 0);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      case (p)
        0: load_config(1, -32768, 0, 0, -32768, 0);
        1: load_config(1, 32767, 255, 65535, 32767, 65535);
        2: load_config(0, int'($urandom_range(0, 6000)) - 3000, $urandom_range(0, 255),
                       $urandom_range(0, 65535), int'($urandom_range(0, 1000)) - 500,
                       $urandom_range(0, 4));
        default:
          load_config(1, int'($urandom_range(0, 6000)) - 3000, $urandom_range(0, 255),
                      $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 2000),
                      int'($urandom_range(0, 1000)) - 500, $urandom_range(0, 4));
      endcase
      repeat (PHASE_ITEMS) random_item();
      settle();
    end

    $display("Summary: %0d items over %0d register settings (winter off, both extremes,",
             items_sent, settings_used);
    $display("  zero and long hold-off); %0d results compared", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off that lets the
  // pipeline fill so the input side has to stall.
  initial begin : result_sink
    int  gap;
    int  taken;
    bit  held_once;
    out_ch.ready = 1'b0;
    taken        = 0;
    held_once    = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (!held_once && taken == 150) begin
        gap       = RESULT_HOLD;
        held_once = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  // Ends the run if neither side moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
